>>> hdl/grc_pkg.sv
// shared types and constants of the grid ray column caster
`timescale 1ns / 1ps
package grc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 21;
  localparam int VEC_W     = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_t;

  localparam logic [POS_W-1:0] POS_X_RST   = 21'd98304;
  localparam logic [POS_W-1:0] POS_Y_RST   = 21'd98304;
  localparam logic [VEC_W-1:0] DIR_X_RST   = 19'h70000;
  localparam logic [VEC_W-1:0] DIR_Y_RST   = 19'd0;
  localparam logic [VEC_W-1:0] PLANE_X_RST = 19'd0;
  localparam logic [VEC_W-1:0] PLANE_Y_RST = 19'd43254;

  typedef enum logic [1:0] {
    SIDE_NORTH = 2'd0,
    SIDE_SOUTH = 2'd1,
    SIDE_WEST  = 2'd2,
    SIDE_EAST  = 2'd3
  } side_t;

  localparam logic [23:0] COLOR_RED   = 24'hFF0000;
  localparam logic [23:0] COLOR_GREEN = 24'h00FF00;
  localparam logic [23:0] COLOR_BLUE  = 24'h0000FF;
  localparam logic [23:0] COLOR_WHITE = 24'hF0F0F0;

  localparam logic [23:0] COLOR_NORTH = COLOR_RED >> 1;
  localparam logic [23:0] COLOR_SOUTH = COLOR_GREEN >> 1;
  localparam logic [23:0] COLOR_WEST  = COLOR_BLUE;
  localparam logic [23:0] COLOR_EAST  = COLOR_WHITE;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [4:0] cell_col;
    logic [4:0] cell_row;
    logic [3:0] cell_value;
    logic [9:0] column;
  } req_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic        hit;
    logic [1:0]  wall_side;
    logic [4:0]  hit_col;
    logic [4:0]  hit_row;
    logic [31:0] perp_dist;
    logic [8:0]  draw_start;
    logic [8:0]  draw_end;
    logic [23:0] wall_color;
  } res_t;

endpackage

>>> hdl/grc_req_if.sv
// request channel: map writes and column casts
`timescale 1ns / 1ps
interface grc_req_if;
  import grc_pkg::*;
  logic valid;
  logic ready;
  req_t pl;
  modport source (output valid, output pl, input ready);
  modport sink (input valid, input pl, output ready);
endinterface

>>> hdl/grc_res_if.sv
// result channel: one record per cast column
`timescale 1ns / 1ps
interface grc_res_if;
  import grc_pkg::*;
  logic valid;
  logic ready;
  res_t pl;
  modport source (output valid, output pl, input ready);
  modport sink (input valid, input pl, output ready);
endinterface

>>> hdl/grc_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps
interface grc_cfg_if;
  import grc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [POS_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/grid_ray_column_caster_top.sv
// grid ray caster: map store, shared divider and dda stepping sequencer
//
// channel | dir | payload                         | handshake
// req     | in  | kind, cell write or cast column | valid/ready
// res     | out | hit record of one cast column   | valid/ready
// cfg     | in  | register index and write data   | valid/ready, always ready
//
// a map write is done as it is taken; a cast runs its four divisions on the shared
// 1 bit per cycle divider and does a map read for each stepped cell
// after reset all MAP_DIM*MAP_DIM cells of the map are cleared with req held off
// one finished result waits in the output register while a new request is taken
`timescale 1ns / 1ps
module grid_ray_column_caster_top #(
  parameter int MAP_DIM       = 32,
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int MAX_STEPS     = 64
) (
  input  logic   clk,
  input  logic   rst,
  grc_req_if.sink   req,
  grc_res_if.source res,
  grc_cfg_if.sink   cfg
);
  import grc_pkg::*;

  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_STEPS + 1);
  localparam int H2    = SCREEN_HEIGHT / 2;
  localparam logic [39:0] CAM_RECIP =
    40'(((64'd1 << 42) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_CAM, ST_RMUL, ST_RAY, ST_RECX, ST_RECY,
    ST_SIDE, ST_STEP, ST_LOOK, ST_LINE, ST_SPAN, ST_OUT
  } state_t;

  state_t state, div_ret;

  // configuration
  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= POS_X_RST;
      pos_y   <= POS_Y_RST;
      dir_x   <= DIR_X_RST;
      dir_y   <= DIR_Y_RST;
      plane_x <= PLANE_X_RST;
      plane_y <= PLANE_Y_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_POS_X:   pos_x   <= cfg.data;
        CFG_POS_Y:   pos_y   <= cfg.data;
        CFG_DIR_X:   dir_x   <= cfg.data[VEC_W-1:0];
        CFG_DIR_Y:   dir_y   <= cfg.data[VEC_W-1:0];
        CFG_PLANE_X: plane_x <= cfg.data[VEC_W-1:0];
        CFG_PLANE_Y: plane_y <= cfg.data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // map store
  logic [3:0]    grid_map [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [3:0]    mem_wdata, map_q;

  // datapath registers
  logic [9:0]         col_q;
  logic signed [19:0] cam;
  logic signed [38:0] prod_x, prod_y;
  logic signed [21:0] rx, ry;
  logic [31:0]        ddx, ddy, perp;
  logic [39:0]        sdx, sdy;
  logic signed [7:0]  mx, my;
  logic [1:0]         side;
  logic [NW-1:0]      nstep;
  res_t               pend;

  // divider
  logic [31:0] div_rem, div_lo, div_den;
  logic [5:0]  div_cnt;
  logic [63:0] dv_num;
  logic [31:0] dv_den;
  logic        dv_sat;
  logic [32:0] dv_trial;
  logic        dv_ge;

  logic accept;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // camera ratio by reciprocal multiplication
  logic signed [14:0] cam_d;
  logic [14:0]        cam_mag;
  logic [44:0]        cam_prod;
  logic [18:0]        cam_q;
  assign cam_d    = $signed({4'b0, col_q, 1'b0}) - 15'(SCREEN_WIDTH);
  assign cam_mag  = cam_d[14] ? 15'(-cam_d) : 15'(cam_d);
  assign cam_prod = 45'(cam_mag) * 45'(CAM_RECIP);
  assign cam_q    = cam_prod[44:26];

  // ray components, truncated toward zero
  logic [38:0] abs_px, abs_py;
  logic [22:0] shx, shy;
  logic signed [21:0] tx, ty;
  assign abs_px = prod_x[38] ? 39'(-prod_x) : 39'(prod_x);
  assign abs_py = prod_y[38] ? 39'(-prod_y) : 39'(prod_y);
  assign shx    = abs_px[38:16];
  assign shy    = abs_py[38:16];
  assign tx     = prod_x[38] ? -$signed({1'b0, shx[20:0]}) : $signed({1'b0, shx[20:0]});
  assign ty     = prod_y[38] ? -$signed({1'b0, shy[20:0]}) : $signed({1'b0, shy[20:0]});

  logic [31:0] mag_rx, mag_ry;
  assign mag_rx = rx[21] ? 32'(-rx) : 32'(rx);
  assign mag_ry = ry[21] ? 32'(-ry) : 32'(ry);

  // initial side distances
  logic [16:0] frac_x, frac_y;
  logic [48:0] side_px, side_py;
  assign frac_x  = rx[21] ? {1'b0, pos_x[15:0]} : 17'h10000 - {1'b0, pos_x[15:0]};
  assign frac_y  = ry[21] ? {1'b0, pos_y[15:0]} : 17'h10000 - {1'b0, pos_y[15:0]};
  assign side_px = frac_x * ddx;
  assign side_py = frac_y * div_lo;

  logic signed [7:0] mx0, my0;
  logic              start_in;
  assign mx0      = {3'b0, pos_x[20:16]};
  assign my0      = {3'b0, pos_y[20:16]};
  assign start_in = (32'(pos_x[20:16]) < MAP_DIM) && (32'(pos_y[20:16]) < MAP_DIM);

  // one dda step
  logic              step_x, out_map;
  logic signed [7:0] mx_n, my_n;
  logic [1:0]        side_n;
  always_comb begin
    step_x = sdy > sdx;
    mx_n   = mx;
    my_n   = my;
    if (step_x) begin
      mx_n   = rx[21] ? mx - 8'sd1 : mx + 8'sd1;
      side_n = (rx > 0) ? SIDE_EAST : SIDE_WEST;
    end else begin
      my_n   = ry[21] ? my - 8'sd1 : my + 8'sd1;
      side_n = (ry > 0) ? SIDE_NORTH : SIDE_SOUTH;
    end
    out_map = mx_n[7] || my_n[7] || ($signed(32'(mx_n)) >= MAP_DIM)
              || ($signed(32'(my_n)) >= MAP_DIM);
  end
  assign rd_addr = AW'($unsigned(32'(my_n)) * MAP_DIM + $unsigned(32'(mx_n)));
  assign mem_re  = (state == ST_STEP) && !out_map;

  // perpendicular distance numerator
  logic              on_x, stp_neg;
  logic signed [8:0] cell_v;
  logic signed [25:0] perp_v;
  logic [25:0]       perp_m;
  assign on_x    = side[1];
  assign stp_neg = on_x ? rx[21] : ry[21];
  assign cell_v  = (on_x ? 9'(mx) : 9'(my)) + (stp_neg ? 9'sd1 : 9'sd0);
  assign perp_v  = {cell_v[8], cell_v, 16'b0} - $signed({5'b0, on_x ? pos_x : pos_y});
  assign perp_m  = perp_v[25] ? 26'(-perp_v) : 26'(perp_v);

  logic steps_done;
  assign steps_done = (32'(nstep) + 1) >= MAX_STEPS;

  // divider operand selection
  always_comb begin
    dv_num = '0;
    dv_den = '0;
    case (state)
      ST_RECX: begin
        dv_num = 64'h1_0000_0000;
        dv_den = mag_rx;
      end
      ST_RECY: begin
        dv_num = 64'h1_0000_0000;
        dv_den = mag_ry;
      end
      ST_LOOK: begin
        dv_num = {22'b0, perp_m, 16'b0};
        dv_den = on_x ? mag_rx : mag_ry;
      end
      ST_LINE: begin
        dv_num = 64'(SCREEN_HEIGHT) << 16;
        dv_den = div_lo;
      end
      default: ;
    endcase
    dv_sat   = (dv_den == 32'd0) || (dv_num[63:32] >= dv_den);
    dv_trial = {div_rem, div_lo[31]};
    dv_ge    = dv_trial >= {1'b0, div_den};
  end

  // span and colour
  logic [30:0]        half;
  logic signed [33:0] s_v, e_v;
  logic [8:0]         ds, de;
  logic [23:0]        color;
  always_comb begin
    half = div_lo[31:1];
    s_v  = 34'(H2) - $signed({3'b0, half});
    e_v  = 34'(H2) + $signed({3'b0, half});
    ds   = s_v[33] ? 9'd0 : s_v[8:0];
    de   = (e_v > 34'(SCREEN_HEIGHT - 1)) ? 9'(SCREEN_HEIGHT - 1) : e_v[8:0];
    case (side)
      SIDE_NORTH: color = COLOR_NORTH;
      SIDE_SOUTH: color = COLOR_SOUTH;
      SIDE_WEST:  color = COLOR_WEST;
      default:    color = COLOR_EAST;
    endcase
  end

  // map write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 4'd0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && req.pl.kind == KIND_WRITE) begin
      mem_we    = (32'(req.pl.cell_col) < MAP_DIM) && (32'(req.pl.cell_row) < MAP_DIM);
      mem_waddr = AW'(32'(req.pl.cell_row) * MAP_DIM + 32'(req.pl.cell_col));
      mem_wdata = req.pl.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_map[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      map_q <= grid_map[rd_addr];
    end
  end

  logic miss;
  always_comb begin
    miss = 1'b0;
    case (state)
      ST_SIDE: miss = !start_in;
      ST_STEP: miss = out_map;
      ST_LOOK: miss = (map_q == 4'd0) && steps_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      div_ret   <= ST_IDLE;
      clr_addr  <= '0;
      nstep     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != ST_OUT) begin
        res.valid <= 1'b0;
      end
      if (state == ST_RECX || state == ST_RECY
          || (state == ST_LOOK && map_q != 4'd0) || state == ST_LINE) begin
        div_rem <= dv_num[63:32];
        div_lo  <= dv_sat ? 32'hFFFF_FFFF : dv_num[31:0];
        div_den <= dv_den;
        div_cnt <= dv_sat ? 6'd0 : 6'd32;
      end
      if (miss) begin
        pend  <= {col_q, {($bits(res_t) - 10){1'b0}}};
        state <= ST_OUT;
      end else begin
        case (state)
          ST_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (32'(clr_addr) == DEPTH - 1) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (accept && req.pl.kind == KIND_CAST) begin
              col_q <= req.pl.column;
              state <= ST_CAM;
            end
          end
          ST_DIV: begin
            if (div_cnt == 6'd0) begin
              state <= div_ret;
            end else begin
              div_cnt <= div_cnt - 1'b1;
              div_rem <= dv_ge ? 32'(dv_trial - {1'b0, div_den}) : dv_trial[31:0];
              div_lo  <= {div_lo[30:0], dv_ge};
            end
          end
          ST_CAM: begin
            cam   <= cam_d[14] ? -$signed({1'b0, cam_q})
                               : $signed({1'b0, cam_q});
            state <= ST_RMUL;
          end
          ST_RMUL: begin
            prod_x <= plane_x * cam;
            prod_y <= plane_y * cam;
            state  <= ST_RAY;
          end
          ST_RAY: begin
            rx    <= 22'(dir_x) + tx;
            ry    <= 22'(dir_y) + ty;
            state <= ST_RECX;
          end
          ST_RECX: begin
            state   <= ST_DIV;
            div_ret <= ST_RECY;
          end
          ST_RECY: begin
            ddx     <= div_lo;
            state   <= ST_DIV;
            div_ret <= ST_SIDE;
          end
          ST_SIDE: begin
            ddy   <= div_lo;
            sdx   <= 40'(side_px[48:16]);
            sdy   <= 40'(side_py[48:16]);
            mx    <= mx0;
            my    <= my0;
            nstep <= '0;
            state <= ST_STEP;
          end
          ST_STEP: begin
            if (step_x) begin
              sdx <= sdx + 40'(ddx);
            end else begin
              sdy <= sdy + 40'(ddy);
            end
            mx    <= mx_n;
            my    <= my_n;
            side  <= side_n;
            state <= ST_LOOK;
          end
          ST_LOOK: begin
            nstep <= nstep + 1'b1;
            if (map_q != 4'd0) begin
              state   <= ST_DIV;
              div_ret <= ST_LINE;
            end else begin
              state <= ST_STEP;
            end
          end
          ST_LINE: begin
            perp    <= div_lo;
            state   <= ST_DIV;
            div_ret <= ST_SPAN;
          end
          ST_SPAN: begin
            pend.out_column <= col_q;
            pend.hit        <= 1'b1;
            pend.wall_side  <= side;
            pend.hit_col    <= mx[4:0];
            pend.hit_row    <= my[4:0];
            pend.perp_dist  <= perp;
            pend.draw_start <= ds;
            pend.draw_end   <= de;
            pend.wall_color <= color;
            state           <= ST_OUT;
          end
          ST_OUT: begin
            if (!res.valid || res.ready) begin
              res.valid <= 1'b1;
              res.pl    <= pend;
              state     <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !req.ready) else $error("request taken during map clear");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.pl.hit |-> res.pl.perp_dist == 32'd0 && res.pl.wall_color == 24'd0)
    else $error("miss record carries data");
  a_hit_color: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.pl.hit |-> res.pl.wall_color != 24'd0)
    else $error("hit record without colour");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    32'(nstep) <= MAX_STEPS) else $error("step count past limit");
`endif

endmodule
